// File: hw/rtl/planar_ascii_hex_line_encoder_unit_macros.svh
// assertion macros for the ascii hex line encoder
// used by the top level only; expects clk and rst in scope
`ifndef PLANAR_ASCII_HEX_LINE_ENCODER_UNIT_MACROS_SVH
`define PLANAR_ASCII_HEX_LINE_ENCODER_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define PAHLE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PAHLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/pahle_pkg.sv
// shared types and codes for the ascii hex line encoder
// no dependencies; used by the controller, datapath and top level
package pahle_pkg;

  // input item kinds (carried in tuser)
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_PULL = 1'b1;

  // configuration register file
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int MODE_W       = 2;
  localparam int LINE_WIDTH_W = 13;
  localparam logic REG_BAND_MODE  = 1'b0;
  localparam logic REG_LINE_WIDTH = 1'b1;

  // band mode codes; any other code acts as single band
  localparam logic [MODE_W-1:0] MODE_LAB       = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FOUR_BAND = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ONE_BAND  = 2'd2;

  localparam logic [MODE_W-1:0]       BAND_MODE_RST  = MODE_LAB;
  localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RST = 13'd4096;

  // controller to datapath commands
  typedef struct packed {
    logic load;      // load item accepted
    logic pull;      // pull item accepted with a line ready
    logic fetch;     // store read data valid, form the byte
    logic emit_adv;  // current character taken by the sink
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic line_ready;  // complete line waits to be drained
    logic last_char;   // character on the output is the final one of the pull
  } stat_t;

endpackage

// File: hw/rtl/planar_ascii_hex_line_encoder_unit.sv
// top level of the ascii hex line encoder: stream ports, apb registers
// depends on pahle_pkg, pahle_ctrl, pahle_dp, pahle_ram and the macros header
//
// Input items either load one pixel (tuser = 0) into the line store or pull the
// next encoded byte (tuser = 1). A load is taken and makes no output; loads
// that arrive while a line is draining are dropped. A pull with a complete
// line waiting yields two uppercase hex characters, plus a newline after every
// WRAP_BYTES encoded bytes and one more after the image's final line; tlast
// marks the final character of the pull. A pull is accepted, then read from
// the registered read port of the line store, and then its characters (2 to 4)
// are offered one by one from the output register; the input side stays
// stalled until the last character of the pull is taken. A pull with no line
// ready is taken and dropped. The line store has no clearing pass: its entries
// are undefined until loaded, so line_width should not be raised while a loaded
// line waits to be drained. Registers: 0x0 band_mode, 0x4 line_width.
`include "planar_ascii_hex_line_encoder_unit_macros.svh"

module planar_ascii_hex_line_encoder_unit #(
  parameter int MAX_WIDTH  = 4096,
  parameter int WRAP_BYTES = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [31:0]                       s_axis_tdata,  // byte_zero, byte_one, byte_two, byte_three
  input  logic                              s_axis_tuser,  // op
  input  logic                              s_axis_tlast,  // image_end
  // output stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [7:0]                        m_axis_tdata,  // char_code, one zero pad bit
  output logic                              m_axis_tlast,  // last
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pahle_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [pahle_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [pahle_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                              pready
);

  logic [pahle_pkg::MODE_W-1:0]       band_mode;
  logic [pahle_pkg::LINE_WIDTH_W-1:0] line_width;
  logic                               reg_idx;
  logic                               cfg_wr;
  pahle_pkg::cmd_t                    cmd;
  pahle_pkg::stat_t                   stat;
  logic [6:0]                         char_code;

  // register decode
  assign reg_idx = paddr[2];
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      band_mode  <= pahle_pkg::BAND_MODE_RST;
      line_width <= pahle_pkg::LINE_WIDTH_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        pahle_pkg::REG_BAND_MODE:  band_mode  <= pwdata[pahle_pkg::MODE_W-1:0];
        pahle_pkg::REG_LINE_WIDTH: line_width <= pwdata[pahle_pkg::LINE_WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      pahle_pkg::REG_BAND_MODE:  prdata = pahle_pkg::CFG_DATA_W'(band_mode);
      pahle_pkg::REG_LINE_WIDTH: prdata = pahle_pkg::CFG_DATA_W'(line_width);
      default:                   prdata = '0;
    endcase
  end

  pahle_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_op     (s_axis_tuser),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  pahle_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .WRAP_BYTES (WRAP_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .band_mode  (band_mode),
    .line_width (line_width),
    .cmd        (cmd),
    .stat       (stat),
    .pixel      (s_axis_tdata),
    .image_end  (s_axis_tlast),
    .char_code  (char_code),
    .last       (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, char_code};

  // one item in flight: never accepting while a character is offered
  `PAHLE_ASSERT_NOW(a_no_overlap, s_axis_tready, !m_axis_tvalid, "input open while output busy")
  // the final character of a pull returns the block to accepting
  `PAHLE_ASSERT_NEXT(a_last_frees_input, m_axis_tvalid && m_axis_tready && m_axis_tlast,
                     s_axis_tready, "input not reopened after last character")
  // a served pull closes the input for the store read cycle
  `PAHLE_ASSERT_NEXT(a_pull_fetch, s_axis_tvalid && s_axis_tready &&
                     (s_axis_tuser == pahle_pkg::OP_PULL) && stat.line_ready,
                     !s_axis_tready && !m_axis_tvalid, "pull did not enter fetch")

endmodule

// File: hw/rtl/pahle_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module pahle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/pahle_ctrl.sv
// controller fsm: item acceptance, store fetch, character emission
// depends on pahle_pkg
module pahle_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_op,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output pahle_pkg::cmd_t  cmd,
  input  pahle_pkg::stat_t stat
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FETCH = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // next state and commands
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == pahle_pkg::OP_LOAD) begin
            cmd.load = 1'b1;
          end else if (stat.line_ready) begin
            cmd.pull   = 1'b1;
            state_next = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.emit_adv = 1'b1;
          if (stat.last_char) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: hw/rtl/pahle_dp.sv
// datapath: line store, load/read counters, wrap counter, hex formatting
// depends on pahle_pkg and pahle_ram
module pahle_dp #(
  parameter int MAX_WIDTH  = 4096,
  parameter int WRAP_BYTES = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [pahle_pkg::MODE_W-1:0]         band_mode,
  input  logic [pahle_pkg::LINE_WIDTH_W-1:0]   line_width,
  input  pahle_pkg::cmd_t                      cmd,
  output pahle_pkg::stat_t                     stat,
  input  logic [31:0]                          pixel,
  input  logic                                 image_end,
  output logic [6:0]                           char_code,
  output logic                                 last
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int EW = (CW > pahle_pkg::LINE_WIDTH_W) ? CW : pahle_pkg::LINE_WIDTH_W;
  localparam int WW = (WRAP_BYTES > 1) ? $clog2(WRAP_BYTES) : 1;

  localparam logic [7:0] FLIP_MASK = 8'h80;
  localparam logic [7:0] FILL_BYTE = 8'hff;
  localparam logic [6:0] CHAR_ZERO = 7'h30;
  localparam logic [6:0] CHAR_A    = 7'h41;
  localparam logic [6:0] CHAR_NL   = 7'd10;
  localparam logic [3:0] NIB_TEN   = 4'd10;

  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    logic [6:0] nib_ext;
    nib_ext = {3'b000, nib};
    if (nib < NIB_TEN) begin
      return CHAR_ZERO + nib_ext;
    end
    return CHAR_A + nib_ext - {3'b000, NIB_TEN};
  endfunction

  function automatic logic [2:0] plane_count(input logic [1:0] mode);
    case (mode)
      pahle_pkg::MODE_LAB:       return 3'd3;
      pahle_pkg::MODE_FOUR_BAND: return 3'd5;
      default:                   return 3'd1;
    endcase
  endfunction

  function automatic logic [7:0] plane_byte(input logic [1:0] mode, input logic [2:0] plane,
                                            input logic [31:0] px);
    logic [7:0] v;
    v = px[8*plane[1:0] +: 8];
    case (mode)
      pahle_pkg::MODE_LAB:       return (plane == 3'd0) ? v : (v ^ FLIP_MASK);
      pahle_pkg::MODE_FOUR_BAND: return (plane >= 3'd4) ? FILL_BYTE : v;
      default:                   return px[7:0];
    endcase
  endfunction

  logic [CW-1:0] load_index;
  logic [AW-1:0] read_index;
  logic [2:0]    read_plane;
  logic          line_ready;
  logic          final_line;
  logic [WW-1:0] wrap_count;
  logic [2:0]    plane_q;
  logic [7:0]    byte_q;
  logic [1:0]    char_idx;
  logic [1:0]    last_idx;

  logic [EW-1:0] lw_ext;
  logic [EW-1:0] eff_ext;
  logic [CW-1:0] eff_w;
  logic          load_room;
  logic [CW-1:0] load_inc;
  logic [CW-1:0] load_after;
  logic [2:0]    pcount;
  logic [2:0]    plane_cl;
  logic [2:0]    plane_inc;
  logic [WW:0]   wrap_inc;
  logic          wrap_hit;
  logic [CW-1:0] read_inc;
  logic          row_end;
  logic          line_done;
  logic          end_nl;
  logic          store_we;
  logic [31:0]   store_rdata;

  // effective line width: zero acts as one, clamp to store depth
  always_comb begin
    lw_ext  = EW'(line_width);
    eff_ext = lw_ext;
    if (lw_ext == '0) begin
      eff_ext = EW'(1);
    end else if (lw_ext > EW'(MAX_WIDTH)) begin
      eff_ext = EW'(MAX_WIDTH);
    end
    eff_w = eff_ext[CW-1:0];
  end

  // load side
  assign load_room  = (load_index < eff_w) && (load_index < CW'(MAX_WIDTH));
  assign load_inc   = load_index + CW'(1);
  assign load_after = load_room ? load_inc : load_index;
  assign store_we   = cmd.load && !line_ready && load_room;

  // pull side: plane clamp, wrap, end of row and end of line
  assign pcount    = plane_count(band_mode);
  assign plane_cl  = (read_plane >= pcount) ? (pcount - 3'd1) : read_plane;
  assign plane_inc = plane_cl + 3'd1;
  assign wrap_inc  = {1'b0, wrap_count} + (WW + 1)'(1);
  assign wrap_hit  = wrap_inc >= (WW + 1)'(WRAP_BYTES);
  assign read_inc  = CW'(read_index) + CW'(1);
  assign row_end   = read_inc >= eff_w;
  assign line_done = row_end && (plane_inc >= pcount);
  assign end_nl    = line_done && final_line;

  pahle_ram #(
    .WIDTH (32),
    .DEPTH (MAX_WIDTH)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (load_index[AW-1:0]),
    .wdata (pixel),
    .raddr (read_index),
    .rdata (store_rdata)
  );

  // line control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      load_index <= '0;
      read_index <= '0;
      read_plane <= '0;
      line_ready <= 1'b0;
      final_line <= 1'b0;
      wrap_count <= '0;
    end else if (cmd.load && !line_ready) begin
      if (load_room) begin
        load_index <= load_inc;
        if (image_end) begin
          final_line <= 1'b1;
        end
      end
      if (load_after >= eff_w) begin
        line_ready <= 1'b1;
      end
    end else if (cmd.pull) begin
      wrap_count <= wrap_hit ? '0 : wrap_inc[WW-1:0];
      if (row_end) begin
        read_index <= '0;
        read_plane <= line_done ? 3'd0 : plane_inc;
      end else begin
        read_index <= read_index + AW'(1);
        read_plane <= plane_cl;
      end
      if (line_done) begin
        line_ready <= 1'b0;
        load_index <= '0;
        if (final_line) begin
          final_line <= 1'b0;
          wrap_count <= '0;
        end
      end
    end
  end

  // per-pull character sequence
  always_ff @(posedge clk) begin
    if (cmd.pull) begin
      plane_q  <= plane_cl;
      last_idx <= 2'd1 + {1'b0, wrap_hit} + {1'b0, end_nl};
    end
    if (cmd.fetch) begin
      byte_q   <= plane_byte(band_mode, plane_q, store_rdata);
      char_idx <= 2'd0;
    end else if (cmd.emit_adv) begin
      char_idx <= char_idx + 2'd1;
    end
  end

  // output character: high nibble, low nibble, then newlines
  always_comb begin
    case (char_idx)
      2'd0:    char_code = hex_char(byte_q[7:4]);
      2'd1:    char_code = hex_char(byte_q[3:0]);
      default: char_code = CHAR_NL;
    endcase
  end

  assign last            = char_idx == last_idx;
  assign stat.line_ready = line_ready;
  assign stat.last_char  = last;

endmodule
